// ----- hdl/pia_pkg.sv -----
// Shared types and constants for the port id allocator.
// No dependencies; used by port_id_allocator_with_hint.
package pia_pkg;

    localparam int PORTS_DEF = 16;    // default number of port slots
    localparam int MAX_RUN   = 16;    // longest unplug notification run

    localparam int ACTION_W   = 3;
    localparam int ID_W       = 4;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 16;   // port_id + new_count, padded to bytes
    localparam int M_TDATA_W  = 24;   // 22 result bits, padded to bytes

    localparam int NOTIFY_IDX = 0;    // register index of notify_unplug

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC   = 3'd0,
        ACT_RELEASE = 3'd1,
        ACT_HINT    = 3'd2,
        ACT_SETCNT  = 3'd3,
        ACT_QUERY   = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_NOPORT = 2'd1,
        STS_NOFREE = 2'd2,
        STS_REJECT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_SHRINK,
        ST_NOTIFY,
        ST_RESP
    } state_t;

endpackage

// ----- hdl/port_id_allocator_with_hint.sv -----
// Port id allocator: free bitmap, one-shot hint, port count updates.
// Depends on pia_pkg (types, action/status codes, widths).

// Hands out port ids from a free bitmap over 0..PORTS present ports. One
// request beat comes in on s_ (action in s_tuser); it produces one result
// beat on m_, or a run of up to 16 beats when a shrink removes ports and
// notify_unplug is set (m_tlast marks the final beat of each run). Requests
// are processed one at a time by a small sequencer around a single scan
// counter that walks the bitmap one id per cycle. Release, hint, query,
// grow and hinted allocate pass through accept, decode and response
// states, and s_tready returns the cycle after the result is loaded. An
// allocate without a hint scans from id 0 upward until it finds a free id
// or reaches the port count. A shrink walks every removed id once to fix
// the free count, then sends the notification beats if notify_unplug is
// set. A stalled m_ side holds the sequencer in place. The free count is
// kept incrementally, so no popcount sits in any path. notify_unplug is
// written through the APB port at byte address 0.
module port_id_allocator_with_hint #(
    parameter int PORTS = pia_pkg::PORTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pia_pkg::S_TDATA_W-1:0] s_tdata,  // [3:0] port_id, [8:4] new_count
    input  logic [pia_pkg::ACTION_W-1:0]  s_tuser,  // [2:0] action
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pia_pkg::M_TDATA_W-1:0] m_tdata,  // [1:0] status, [5:2] granted_id,
                                                    // [10:6] free_count, [15:11] port_count,
                                                    // [16] id_free, [17] id_registered,
                                                    // [21:18] unplugged_id
    output logic                          m_tlast,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int PW   = $clog2(PORTS + 1);            // counts 0..PORTS
    localparam int IW   = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int CMPW = (PW > pia_pkg::COUNT_W) ? PW : pia_pkg::COUNT_W;

    // ---------------- registers ----------------
    pia_pkg::state_t  state_reg, state_next;
    pia_pkg::action_t act_reg, act_next;
    logic [pia_pkg::ID_W-1:0]     id_reg, id_next;
    logic [PW-1:0]                req_reg, req_next;       // saturated new count
    logic [PW-1:0]                end_reg, end_next;       // end of notify run
    logic [PW-1:0]                scan_reg, scan_next;     // shared scan counter
    pia_pkg::status_t             status_reg, status_next;
    logic [pia_pkg::ID_W-1:0]     grant_reg, grant_next;
    logic [PORTS-1:0]             free_map_reg, free_map_next;
    logic [PW-1:0]                port_total_reg, port_total_next;
    logic [PW-1:0]                free_cnt_reg, free_cnt_next;
    logic                         hint_valid_reg, hint_valid_next;
    logic [IW-1:0]                hint_index_reg, hint_index_next;
    logic                         notify_reg, notify_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [pia_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                         m_tlast_reg, m_tlast_next;

    // ---------------- handshakes ----------------
    logic s_fire;
    logic cfg_wr;
    logic slot_free;     // output register can take a beat this cycle
    logic emit_req;      // sequencer has a beat to send
    logic emit_load;
    logic emit_last;
    pia_pkg::status_t             emit_status;
    logic [pia_pkg::ID_W-1:0]     emit_grant;
    logic [pia_pkg::ID_W-1:0]     emit_unplug;

    assign s_tready  = (state_reg == pia_pkg::ST_IDLE);
    assign s_fire    = s_tvalid & s_tready;
    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite & pready;
    assign slot_free = ~m_tvalid_reg | m_tready;
    assign emit_load = emit_req & slot_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign prdata = (paddr[2] == 1'(pia_pkg::NOTIFY_IDX)) ? {31'd0, notify_reg} : 32'd0;

    // ---------------- lookups on current state ----------------
    logic          id_in_range;
    logic          id_bit_free;
    logic          scan_at_end;      // scan reached port_total
    logic          scan_bit_free;
    logic          shrink_last;      // last removed id in the walk
    logic          notify_last;      // last beat of the notify run
    logic [PW-1:0] req_sat;
    logic [CMPW-1:0] req_wide;
    logic [PW-1:0]   shrink_span;

    assign id_in_range   = CMPW'(id_reg) < CMPW'(port_total_reg);
    assign id_bit_free   = free_map_reg[IW'(id_reg)];
    assign scan_at_end   = scan_reg >= port_total_reg;
    assign scan_bit_free = free_map_reg[scan_reg[IW-1:0]];
    assign shrink_last   = ((PW+1)'(scan_reg) + (PW+1)'(1)) == (PW+1)'(port_total_reg);
    assign notify_last   = ((PW+1)'(scan_reg) + (PW+1)'(1)) == (PW+1)'(end_reg);
    assign shrink_span   = port_total_reg - req_reg;

    // new_count saturates at PORTS
    assign req_wide = CMPW'(s_tdata[8:4]);
    assign req_sat  = (req_wide > CMPW'(PORTS)) ? PW'(PORTS) : PW'(req_wide);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pia_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = pia_pkg::ST_DECODE;
                end
            end
            pia_pkg::ST_DECODE: begin
                state_next = pia_pkg::ST_RESP;
                if (act_reg == pia_pkg::ACT_ALLOC && port_total_reg != '0 &&
                    !hint_valid_reg) begin
                    state_next = pia_pkg::ST_SEARCH;
                end else if (act_reg == pia_pkg::ACT_SETCNT &&
                             req_reg < port_total_reg) begin
                    state_next = pia_pkg::ST_SHRINK;
                end
            end
            pia_pkg::ST_SEARCH: begin
                if (scan_at_end || scan_bit_free) begin
                    state_next = pia_pkg::ST_RESP;
                end
            end
            pia_pkg::ST_SHRINK: begin
                if (shrink_last) begin
                    state_next = notify_reg ? pia_pkg::ST_NOTIFY : pia_pkg::ST_RESP;
                end
            end
            pia_pkg::ST_NOTIFY: begin
                if (emit_load && notify_last) begin
                    state_next = pia_pkg::ST_IDLE;
                end
            end
            pia_pkg::ST_RESP: begin
                if (emit_load) begin
                    state_next = pia_pkg::ST_IDLE;
                end
            end
            default: state_next = pia_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        act_next        = act_reg;
        id_next         = id_reg;
        req_next        = req_reg;
        end_next        = end_reg;
        scan_next       = scan_reg;
        status_next     = status_reg;
        grant_next      = grant_reg;
        free_map_next   = free_map_reg;
        port_total_next = port_total_reg;
        free_cnt_next   = free_cnt_reg;
        hint_valid_next = hint_valid_reg;
        hint_index_next = hint_index_reg;
        notify_next     = notify_reg;
        emit_req        = 1'b0;
        emit_last       = 1'b1;
        emit_status     = status_reg;
        emit_grant      = grant_reg;
        emit_unplug     = '0;

        if (cfg_wr && paddr[2] == 1'(pia_pkg::NOTIFY_IDX)) begin
            notify_next = pwdata[0];
        end

        case (state_reg)
            pia_pkg::ST_IDLE: begin
                if (s_fire) begin
                    act_next = pia_pkg::action_t'(s_tuser);
                    id_next  = s_tdata[3:0];
                    req_next = req_sat;
                end
            end
            pia_pkg::ST_DECODE: begin
                grant_next  = '0;
                status_next = pia_pkg::STS_OK;
                scan_next   = '0;
                case (act_reg)
                    pia_pkg::ACT_ALLOC: begin
                        if (port_total_reg == '0) begin
                            status_next = pia_pkg::STS_NOPORT;
                        end else if (hint_valid_reg) begin
                            // hinted id may have been taken by a plain allocate
                            grant_next      = pia_pkg::ID_W'(hint_index_reg);
                            hint_valid_next = 1'b0;
                            free_map_next[hint_index_reg] = 1'b0;
                            if (free_map_reg[hint_index_reg]) begin
                                free_cnt_next = free_cnt_reg - PW'(1);
                            end
                        end
                    end
                    pia_pkg::ACT_RELEASE: begin
                        if (id_in_range) begin
                            free_map_next[IW'(id_reg)] = 1'b1;
                            if (!id_bit_free) begin
                                free_cnt_next = free_cnt_reg + PW'(1);
                            end
                        end else begin
                            status_next = pia_pkg::STS_REJECT;
                        end
                    end
                    pia_pkg::ACT_HINT: begin
                        if (id_in_range && id_bit_free) begin
                            hint_valid_next = 1'b1;
                            hint_index_next = IW'(id_reg);
                        end else begin
                            status_next = pia_pkg::STS_REJECT;
                        end
                    end
                    pia_pkg::ACT_SETCNT: begin
                        if (req_reg < port_total_reg) begin
                            scan_next = req_reg;
                            if (CMPW'(shrink_span) > CMPW'(pia_pkg::MAX_RUN)) begin
                                end_next = PW'(CMPW'(req_reg) + CMPW'(pia_pkg::MAX_RUN));
                            end else begin
                                end_next = port_total_reg;
                            end
                        end else if (req_reg > port_total_reg) begin
                            // slots above port_total are always marked free
                            free_cnt_next   = free_cnt_reg + (req_reg - port_total_reg);
                            port_total_next = req_reg;
                        end
                    end
                    pia_pkg::ACT_QUERY: begin
                        if (!id_in_range) begin
                            status_next = pia_pkg::STS_REJECT;
                        end
                    end
                    default: status_next = pia_pkg::STS_REJECT;
                endcase
            end
            pia_pkg::ST_SEARCH: begin
                if (scan_at_end) begin
                    status_next = pia_pkg::STS_NOFREE;
                end else if (scan_bit_free) begin
                    free_map_next[scan_reg[IW-1:0]] = 1'b0;
                    free_cnt_next = free_cnt_reg - PW'(1);
                    grant_next    = pia_pkg::ID_W'(scan_reg);
                end else begin
                    scan_next = scan_reg + PW'(1);
                end
            end
            pia_pkg::ST_SHRINK: begin
                // drop each removed id from the free count, mark it free
                if (scan_bit_free) begin
                    free_cnt_next = free_cnt_reg - PW'(1);
                end
                free_map_next[scan_reg[IW-1:0]] = 1'b1;
                scan_next = scan_reg + PW'(1);
                if (shrink_last) begin
                    port_total_next = req_reg;
                    scan_next       = req_reg;
                    if (hint_valid_reg && PW'(hint_index_reg) >= req_reg) begin
                        hint_valid_next = 1'b0;
                        hint_index_next = '0;
                    end
                end
            end
            pia_pkg::ST_NOTIFY: begin
                emit_req    = 1'b1;
                emit_status = pia_pkg::STS_OK;
                emit_grant  = '0;
                emit_unplug = pia_pkg::ID_W'(scan_reg);
                emit_last   = notify_last;
                if (emit_load) begin
                    scan_next = scan_reg + PW'(1);
                end
            end
            pia_pkg::ST_RESP: begin
                emit_req = 1'b1;
            end
            default: ;
        endcase
    end

    // output register: one beat in flight toward m_
    logic id_free_out;
    assign id_free_out = id_in_range & id_bit_free;

    always_comb begin
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit_load) begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = emit_last;
            m_tdata_next  = {2'b00,
                             emit_unplug,
                             id_in_range & ~id_bit_free,
                             id_free_out,
                             pia_pkg::COUNT_W'(port_total_reg),
                             pia_pkg::COUNT_W'(free_cnt_reg),
                             emit_grant,
                             emit_status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pia_pkg::ST_IDLE;
            free_map_reg   <= '1;
            port_total_reg <= '0;
            free_cnt_reg   <= '0;
            hint_valid_reg <= 1'b0;
            hint_index_reg <= '0;
            notify_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_map_reg   <= free_map_next;
            port_total_reg <= port_total_next;
            free_cnt_reg   <= free_cnt_next;
            hint_valid_reg <= hint_valid_next;
            hint_index_reg <= hint_index_next;
            notify_reg     <= notify_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        id_reg      <= id_next;
        req_reg     <= req_next;
        end_reg     <= end_next;
        scan_reg    <= scan_next;
        status_reg  <= status_next;
        grant_reg   <= grant_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // ---------------- assertions ----------------
    // between requests the incremental free count matches the bitmap
    a_free_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pia_pkg::ST_IDLE) |->
        ($countones(free_map_reg & ~({PORTS{1'b1}} << port_total_reg))
            == int'(free_cnt_reg)))
        else $error("free count out of step with bitmap");

    // slots above the port count always read as free
    a_tail_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pia_pkg::ST_IDLE) |->
        ((free_map_reg >> port_total_reg) == ({PORTS{1'b1}} >> port_total_reg)))
        else $error("slot above port count not free");

    // a live hint always points at a present port
    a_hint_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pia_pkg::ST_IDLE && hint_valid_reg) |->
        (PW'(hint_index_reg) < port_total_reg))
        else $error("hint outside port range");

    // a beat is only loaded by the response or notify states
    a_emit_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid_reg) && $past(aresetn)) |->
        ($past(state_reg) == pia_pkg::ST_RESP || $past(state_reg) == pia_pkg::ST_NOTIFY))
        else $error("result beat without response state");

endmodule
